FILE: rtl/dfrq_pkg.sv
// Shared constants for the direction-filtered ring queue.
// Port widths and operation codes; no dependencies.
package dfrq_pkg;

  localparam int IN_PAY_W  = 32;  // payload port width
  localparam int OUT_PAY_W = 32;  // result payload width
  localparam int COUNT_W   = 5;   // reported count width (wraps modulo 32)

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

endpackage

FILE: rtl/direction_filtered_ring_queue_unit.sv
// Direction-filtered overwriting ring queue: top level and sequencer.
// Uses dfrq_pkg and the entry memory dfrq_ram.
//
//  channel | ports                                           | handshake
//  --------+-------------------------------------------------+---------------------------
//  input   | in_mode, in_direction, in_payload               | start & !busy
//  result  | out_found, out_overwrote, out_direction,        | out_valid, one cycle,
//          | out_payload, out_matching_count, out_total_count| no back-pressure
//
// Push: completes in the idle state, or via S_PUSH when the queue is full (the
// dropped entry is read back to update the per-direction count). Pop: done in
// the idle state when no entry matches; otherwise the single RAM read port
// walks the ring once, finding the match and then shifting later entries down.
// The result strobe comes the cycle after the last step; busy is high meanwhile.
// Reset (synchronous, rst_n low) empties the queue; entry memory is not cleared.
module direction_filtered_ring_queue_unit #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_mode,
  input  logic                            in_direction,
  input  logic [dfrq_pkg::IN_PAY_W-1:0]   in_payload,
  output logic                            out_valid,
  output logic                            out_found,
  output logic                            out_overwrote,
  output logic                            out_direction,
  output logic [dfrq_pkg::OUT_PAY_W-1:0]  out_payload,
  output logic [dfrq_pkg::COUNT_W-1:0]    out_matching_count,
  output logic [dfrq_pkg::COUNT_W-1:0]    out_total_count
);

  import dfrq_pkg::*;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = PAYLOAD_BITS + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PUSH  = 2'd1;  // full push, dropped entry on read port
  localparam logic [1:0] S_SCAN  = 2'd2;  // looking for the oldest match
  localparam logic [1:0] S_SHIFT = 2'd3;  // closing the gap

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [OUT_PAY_W-1:0] to_out_pay(input logic [PAYLOAD_BITS-1:0] b);
    logic [63:0] wide;
    wide = 64'(b);
    return wide[OUT_PAY_W-1:0];
  endfunction

  // control state
  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] oldest_r, oldest_nxt;
  logic [IDX_W-1:0] nw_r, nw_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ones_r, ones_nxt;
  logic             out_valid_r, out_valid_nxt;

  // working registers
  logic                    dir_r, dir_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [IDX_W-1:0]        rd_pos_r, rd_pos_nxt;
  logic [IDX_W-1:0]        data_pos_r, data_pos_nxt;
  logic [CNT_W-1:0]        data_idx_r, data_idx_nxt;
  logic [IDX_W-1:0]        wr_pos_r, wr_pos_nxt;
  logic [CNT_W-1:0]        wr_idx_r, wr_idx_nxt;

  // result registers
  logic                 found_r, found_nxt;
  logic                 ovw_r, ovw_nxt;
  logic                 odir_r, odir_nxt;
  logic [OUT_PAY_W-1:0] opay_r, opay_nxt;
  logic [COUNT_W-1:0]   omatch_r, omatch_nxt;
  logic [COUNT_W-1:0]   ototal_r, ototal_nxt;

  // memory port
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic               accept;
  logic               full;
  logic [CNT_W-1:0]   match_now;
  logic               rd_dir;
  logic [CNT_W:0]     wr_idx_p2;

  dfrq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign match_now = in_direction ? ones_r : cnt_r - ones_r;
  assign rd_dir    = ram_rdata[PAYLOAD_BITS];
  assign wr_idx_p2 = {1'b0, wr_idx_r} + (CNT_W + 1)'(2);

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    nw_nxt        = nw_r;
    cnt_nxt       = cnt_r;
    ones_nxt      = ones_r;
    out_valid_nxt = 1'b0;
    dir_nxt       = dir_r;
    pay_nxt       = pay_r;
    rd_pos_nxt    = rd_pos_r;
    data_pos_nxt  = data_pos_r;
    data_idx_nxt  = data_idx_r;
    wr_pos_nxt    = wr_pos_r;
    wr_idx_nxt    = wr_idx_r;
    found_nxt     = found_r;
    ovw_nxt       = ovw_r;
    odir_nxt      = odir_r;
    opay_nxt      = opay_r;
    omatch_nxt    = omatch_r;
    ototal_nxt    = ototal_r;
    ram_we        = 1'b0;
    ram_waddr     = nw_r;
    ram_wdata     = {dir_r, pay_r};
    ram_re        = 1'b0;
    ram_raddr     = rd_pos_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          dir_nxt    = in_direction;
          pay_nxt    = PAYLOAD_BITS'({32'b0, in_payload});
          omatch_nxt = COUNT_W'(match_now);
          odir_nxt   = 1'b0;
          opay_nxt   = '0;
          ovw_nxt    = 1'b0;
          if (in_mode == MODE_PUSH) begin
            found_nxt = 1'b1;
            if (full) begin
              // oldest slot is the write slot; fetch its tag first
              ram_re    = 1'b1;
              ram_raddr = oldest_r;
              state_nxt = S_PUSH;
            end else begin
              ram_we        = 1'b1;
              ram_wdata     = {in_direction, PAYLOAD_BITS'({32'b0, in_payload})};
              nw_nxt        = ptr_inc(nw_r);
              cnt_nxt       = cnt_r + 1'b1;
              ones_nxt      = ones_r + CNT_W'(in_direction);
              ototal_nxt    = COUNT_W'(cnt_r + 1'b1);
              out_valid_nxt = 1'b1;
            end
          end else begin
            if (match_now == '0) begin
              found_nxt     = 1'b0;
              ototal_nxt    = COUNT_W'(cnt_r);
              out_valid_nxt = 1'b1;
            end else begin
              ram_re       = 1'b1;
              ram_raddr    = oldest_r;
              rd_pos_nxt   = ptr_inc(oldest_r);
              data_pos_nxt = oldest_r;
              data_idx_nxt = '0;
              state_nxt    = S_SCAN;
            end
          end
        end
      end

      S_PUSH: begin
        ram_we        = 1'b1;
        ones_nxt      = ones_r - CNT_W'(rd_dir) + CNT_W'(dir_r);
        oldest_nxt    = ptr_inc(oldest_r);
        nw_nxt        = ptr_inc(nw_r);
        ovw_nxt       = 1'b1;
        ototal_nxt    = COUNT_W'(cnt_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_SCAN: begin
        // read one ahead; the match is guaranteed since the count was nonzero
        ram_re       = 1'b1;
        rd_pos_nxt   = ptr_inc(rd_pos_r);
        data_pos_nxt = rd_pos_r;
        data_idx_nxt = data_idx_r + 1'b1;
        if (rd_dir == dir_r) begin
          odir_nxt = rd_dir;
          opay_nxt = to_out_pay(ram_rdata[PAYLOAD_BITS-1:0]);
          if (data_idx_r + 1'b1 == cnt_r) begin
            found_nxt     = 1'b1;
            cnt_nxt       = cnt_r - 1'b1;
            ones_nxt      = ones_r - CNT_W'(dir_r);
            nw_nxt        = ptr_dec(nw_r);
            ototal_nxt    = COUNT_W'(cnt_r - 1'b1);
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            wr_pos_nxt = data_pos_r;
            wr_idx_nxt = data_idx_r;
            state_nxt  = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        ram_we     = 1'b1;
        ram_waddr  = wr_pos_r;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b1;
        rd_pos_nxt = ptr_inc(rd_pos_r);
        wr_pos_nxt = ptr_inc(wr_pos_r);
        wr_idx_nxt = wr_idx_r + 1'b1;
        if (wr_idx_p2 == {1'b0, cnt_r}) begin
          found_nxt     = 1'b1;
          cnt_nxt       = cnt_r - 1'b1;
          ones_nxt      = ones_r - CNT_W'(dir_r);
          nw_nxt        = ptr_dec(nw_r);
          ototal_nxt    = COUNT_W'(cnt_r - 1'b1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      nw_r        <= '0;
      cnt_r       <= '0;
      ones_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      nw_r        <= nw_nxt;
      cnt_r       <= cnt_nxt;
      ones_r      <= ones_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_r      <= dir_nxt;
    pay_r      <= pay_nxt;
    rd_pos_r   <= rd_pos_nxt;
    data_pos_r <= data_pos_nxt;
    data_idx_r <= data_idx_nxt;
    wr_pos_r   <= wr_pos_nxt;
    wr_idx_r   <= wr_idx_nxt;
    found_r    <= found_nxt;
    ovw_r      <= ovw_nxt;
    odir_r     <= odir_nxt;
    opay_r     <= opay_nxt;
    omatch_r   <= omatch_nxt;
    ototal_r   <= ototal_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = found_r;
  assign out_overwrote      = ovw_r;
  assign out_direction      = odir_r;
  assign out_payload        = opay_r;
  assign out_matching_count = omatch_r;
  assign out_total_count    = ototal_r;

  // write pointer must always sit count slots past the oldest entry
  logic [IDX_W:0] chk_sum;
  logic [IDX_W:0] chk_wrap;
  assign chk_sum  = (IDX_W + 1)'(oldest_r) + (IDX_W + 1)'(cnt_r);
  assign chk_wrap = (chk_sum >= (IDX_W + 1)'(QUEUE_DEPTH)) ?
                    chk_sum - (IDX_W + 1)'(QUEUE_DEPTH) : chk_sum;

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    nw_r == chk_wrap[IDX_W-1:0])
    else $error("write pointer out of step with oldest pointer and count");

  a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CNT_W'(QUEUE_DEPTH)) && (ones_r <= cnt_r))
    else $error("entry counts out of range");

  a_fast_push: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_PUSH) && !full) |=> (out_valid && !busy))
    else $error("non-full push did not complete in one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer busy");

endmodule

FILE: rtl/dfrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfrq_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
